>>> sv/gbts_pkg.sv
// gbts_pkg: command codes and fixed field widths of the gap buffer text store
// no dependencies; imported by every module of the block
package gbts_pkg;

   // command codes carried in the low bits of the request beat
   localparam logic [2:0] CMD_READ     = 3'd0;
   localparam logic [2:0] CMD_INSERT   = 3'd1;
   localparam logic [2:0] CMD_DEL_FWD  = 3'd2;
   localparam logic [2:0] CMD_DEL_BACK = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;

   // field widths
   localparam int CMD_W  = 3;
   localparam int POS_W  = 13;
   localparam int BYTE_W = 8;
   localparam int REQ_W  = 56;
   localparam int RSP_W  = 24;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [BYTE_W-1:0] byte_type;

endpackage

>>> sv/gbts_alu.sv
// gbts_alu: shared add/subtract unit with borrow and zero flags
// depends on gbts_pkg; used by the sequencer in gap_buffer_text_store
module gbts_alu
   import gbts_pkg::*;
#(
   parameter int WIDTH = 13
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             op_sub,
   output logic [WIDTH-1:0] result,
   output logic             borrow,
   output logic             zero
);

   logic [WIDTH:0] wide;

   // one adder serves both directions; the top bit is the borrow on subtract
   always_comb begin
      if (op_sub) begin
         wide = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         wide = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   assign result = wide[WIDTH-1:0];
   assign borrow = op_sub & wide[WIDTH];
   assign zero   = (wide[WIDTH-1:0] == '0);

endmodule

>>> sv/gbts_store.sv
// gbts_store: text byte memory, one write and one registered read per cycle
// depends on gbts_pkg; instantiated by gap_buffer_text_store
module gbts_store
   import gbts_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  byte_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output byte_type      rd_data
);

   byte_type text_store_ff [DEPTH];
   byte_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= text_store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/gap_buffer_text_store.sv
// gap_buffer_text_store: top level, command sequencer around a shared adder
// depends on gbts_pkg, gbts_alu and gbts_store
//
// usage
//   one command per request beat: read, insert byte, delete forward,
//   delete backward or clear; every command returns exactly one response
//   beat with accepted, read byte, read valid, at-gap flag and text length.
//   req_tready is high only while the sequencer is idle; one command is
//   worked at a time. a finished response sits in an output register, so
//   the next command is taken while that response waits for rsp_tready.
// sequence
//   clear and unknown codes go straight to the final step. a read, insert
//   or delete first checks its position against the text; a read then maps
//   it to a store address, an insert checks the room and a delete clamps
//   its count, and both move the gap. every byte the gap moves past costs
//   one compare, one memory read and one memory write, with the pointer
//   stepped through the single shared adder, so a long cursor jump costs
//   work for every byte between the old and the new cursor.
// reset
//   synchronous, active high: the text is empty, the gap starts at zero and
//   spans the whole store. the store itself is not cleared; only bytes that
//   were inserted are ever read back.
// stall
//   while the response register is full and rsp_tready is low, a finished
//   command waits in its last step; no command is taken until the register frees.
module gap_buffer_text_store
   import gbts_pkg::*;
#(
   parameter int CAPACITY = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // lsb up: command[3], position[13], data_byte[8], run_remaining[13],
   // delete_count[13], zero fill[6]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // lsb up: accepted[1], read_byte[8], read_valid[1], at_gap[1],
   // text_length[13]
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > POS_W) ? LW : POS_W;

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_RANGE  = 5'd1;
   localparam logic [4:0] S_BCLAMP = 5'd2;
   localparam logic [4:0] S_DCLAMP = 5'd3;
   localparam logic [4:0] S_RPHYS  = 5'd4;
   localparam logic [4:0] S_RADD   = 5'd5;
   localparam logic [4:0] S_RWAIT  = 5'd6;
   localparam logic [4:0] S_ROOM   = 5'd7;
   localparam logic [4:0] S_MOVE   = 5'd8;
   localparam logic [4:0] S_ML_RD  = 5'd9;
   localparam logic [4:0] S_ML_WR  = 5'd10;
   localparam logic [4:0] S_MR_RD  = 5'd11;
   localparam logic [4:0] S_MR_WR  = 5'd12;
   localparam logic [4:0] S_INS_A  = 5'd13;
   localparam logic [4:0] S_INS_B  = 5'd14;
   localparam logic [4:0] S_INS_C  = 5'd15;
   localparam logic [4:0] S_DEL_A  = 5'd16;
   localparam logic [4:0] S_DEL_B  = 5'd17;
   localparam logic [4:0] S_DONE   = 5'd18;

   logic [4:0]    state_ff, state_in;
   logic [LW-1:0] gap_start_ff, gap_start_in;
   logic [LW-1:0] gap_length_ff, gap_length_in;
   logic [LW-1:0] text_len_ff, text_len_in;
   logic [LW-1:0] dest_ff, dest_in;
   cmd_type       cmd_ff, cmd_in;
   pos_type       pos_ff, pos_in;
   byte_type      byte_ff, byte_in;
   pos_type       need_ff, need_in;
   pos_type       cnt_ff, cnt_in;
   logic          end_ff, end_in;
   logic          acc_ff, acc_in;
   logic          rvalid_ff, rvalid_in;
   logic          atgap_ff, atgap_in;
   byte_type      rbyte_ff, rbyte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0] alu_a, alu_b, alu_res;
   logic          alu_sub, alu_borrow, alu_zero;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   byte_type      mem_wdata, mem_rdata;

   // request beat fields
   cmd_type  req_cmd;
   pos_type  req_pos, req_run, req_cnt;
   byte_type req_byte;
   assign req_cmd  = req_tdata[2:0];
   assign req_pos  = req_tdata[15:3];
   assign req_byte = req_tdata[23:16];
   assign req_run  = req_tdata[36:24];
   assign req_cnt  = req_tdata[49:37];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   gbts_alu #(.WIDTH(CW)) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow),
      .zero   (alu_zero)
   );

   gbts_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // operand select for the shared adder
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_RANGE:  begin alu_a = CW'(text_len_ff);  alu_b = CW'(pos_ff); end
         S_BCLAMP: begin alu_a = CW'(pos_ff);       alu_b = CW'(cnt_ff); end
         S_DCLAMP: begin alu_a = CW'(text_len_ff);  alu_b = CW'(dest_ff); end
         S_RPHYS:  begin alu_a = CW'(pos_ff);       alu_b = CW'(gap_start_ff); end
         S_RADD: begin
            alu_a = CW'(pos_ff); alu_b = CW'(gap_length_ff); alu_sub = 1'b0;
         end
         S_ROOM:   begin alu_a = CW'(gap_length_ff); alu_b = CW'(need_ff); end
         S_MOVE:   begin alu_a = CW'(dest_ff);       alu_b = CW'(gap_start_ff); end
         S_ML_RD:  begin alu_a = CW'(gap_start_ff);  alu_b = CW'(1); end
         S_ML_WR, S_MR_RD: begin
            alu_a = CW'(gap_start_ff); alu_b = CW'(gap_length_ff); alu_sub = 1'b0;
         end
         S_MR_WR, S_INS_B: begin
            alu_a = CW'(gap_start_ff); alu_b = CW'(1); alu_sub = 1'b0;
         end
         S_INS_A:  begin alu_a = CW'(gap_length_ff); alu_b = CW'(1); end
         S_INS_C: begin
            alu_a = CW'(text_len_ff); alu_b = CW'(1); alu_sub = 1'b0;
         end
         S_DEL_A: begin
            alu_a = CW'(gap_length_ff); alu_b = CW'(cnt_ff); alu_sub = 1'b0;
         end
         S_DEL_B:  begin alu_a = CW'(text_len_ff); alu_b = CW'(cnt_ff); end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   // memory port drive
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata;
      mem_raddr = '0;
      unique case (state_ff)
         S_RPHYS:          mem_raddr = pos_ff[AW-1:0];
         S_RADD:           mem_raddr = alu_res[AW-1:0];
         S_ML_RD, S_MR_RD: mem_raddr = alu_res[AW-1:0];
         S_ML_WR: begin
            mem_we    = 1'b1;
            mem_waddr = alu_res[AW-1:0];
         end
         S_MR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = gap_start_ff[AW-1:0];
         end
         S_INS_A: begin
            mem_we    = 1'b1;
            mem_waddr = gap_start_ff[AW-1:0];
            mem_wdata = byte_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      gap_start_in  = gap_start_ff;
      gap_length_in = gap_length_ff;
      text_len_in   = text_len_ff;
      dest_in       = dest_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      byte_in       = byte_ff;
      need_in       = need_ff;
      cnt_in        = cnt_ff;
      end_in        = end_ff;
      acc_in        = acc_ff;
      rvalid_in     = rvalid_ff;
      atgap_in      = atgap_ff;
      rbyte_in      = rbyte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_cmd;
               pos_in    = req_pos;
               byte_in   = req_byte;
               need_in   = (req_run == '0) ? POS_W'(1) : req_run;
               cnt_in    = req_cnt;
               acc_in    = 1'b0;
               rvalid_in = 1'b0;
               atgap_in  = 1'b0;
               rbyte_in  = '0;
               if (req_cmd == CMD_CLEAR) begin
                  gap_start_in  = '0;
                  gap_length_in = LW'(CAPACITY);
                  text_len_in   = '0;
                  acc_in        = 1'b1;
                  state_in      = S_DONE;
               end else if (req_cmd == CMD_READ || req_cmd == CMD_INSERT ||
                            req_cmd == CMD_DEL_FWD || req_cmd == CMD_DEL_BACK) begin
                  state_in = S_RANGE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RANGE: begin
            // position beyond the text rejects every command
            if (alu_borrow) begin
               state_in = S_DONE;
            end else if (cmd_ff == CMD_READ) begin
               acc_in   = 1'b1;
               end_in   = alu_zero;
               state_in = S_RPHYS;
            end else if (cmd_ff == CMD_INSERT) begin
               state_in = S_ROOM;
            end else begin
               acc_in = 1'b1;
               if (cnt_ff == '0 || (cmd_ff == CMD_DEL_BACK && pos_ff == '0)) begin
                  state_in = S_DONE;
               end else if (cmd_ff == CMD_DEL_BACK) begin
                  state_in = S_BCLAMP;
               end else begin
                  dest_in  = LW'(pos_ff);
                  state_in = S_DCLAMP;
               end
            end
         end
         S_BCLAMP: begin
            // backspace cannot reach before the start of the text
            if (alu_borrow) begin
               cnt_in  = pos_ff;
               dest_in = '0;
            end else begin
               dest_in = alu_res[LW-1:0];
            end
            state_in = S_DCLAMP;
         end
         S_DCLAMP: begin
            // clamp to the text after the edit start
            if (CW'(cnt_ff) > alu_res) begin
               cnt_in = alu_res[POS_W-1:0];
            end
            state_in = S_MOVE;
         end
         S_ROOM: begin
            if (alu_borrow) begin
               state_in = S_DONE;
            end else begin
               acc_in   = 1'b1;
               dest_in  = LW'(pos_ff);
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            priority if (alu_zero) begin
               state_in = (cmd_ff == CMD_INSERT) ? S_INS_A : S_DEL_A;
            end else if (alu_borrow) begin
               state_in = S_ML_RD;
            end else begin
               state_in = S_MR_RD;
            end
         end
         S_ML_RD: begin
            gap_start_in = alu_res[LW-1:0];
            state_in     = S_ML_WR;
         end
         S_ML_WR: state_in = S_MOVE;
         S_MR_RD: state_in = S_MR_WR;
         S_MR_WR: begin
            gap_start_in = alu_res[LW-1:0];
            state_in     = S_MOVE;
         end
         S_INS_A: begin
            // shrink the gap first so it never reaches past the store end
            gap_length_in = alu_res[LW-1:0];
            state_in      = S_INS_B;
         end
         S_INS_B: begin
            gap_start_in = alu_res[LW-1:0];
            state_in     = S_INS_C;
         end
         S_INS_C: begin
            text_len_in = alu_res[LW-1:0];
            state_in    = S_DONE;
         end
         S_DEL_A: begin
            gap_length_in = alu_res[LW-1:0];
            state_in      = S_DEL_B;
         end
         S_DEL_B: begin
            text_len_in = alu_res[LW-1:0];
            state_in    = S_DONE;
         end
         S_RPHYS: begin
            // below the gap the logical index is the physical one
            atgap_in = alu_zero;
            priority if (end_ff) begin
               state_in = S_DONE;
            end else if (alu_borrow) begin
               state_in = S_RWAIT;
            end else begin
               state_in = S_RADD;
            end
         end
         S_RADD: state_in = S_RWAIT;
         S_RWAIT: begin
            rbyte_in  = mem_rdata;
            rvalid_in = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {POS_W'(text_len_ff), atgap_ff, rvalid_ff, rbyte_ff, acc_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gap_start_ff  <= '0;
         gap_length_ff <= LW'(CAPACITY);
         text_len_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gap_start_ff  <= gap_start_in;
         gap_length_ff <= gap_length_in;
         text_len_ff   <= text_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      byte_ff     <= byte_in;
      need_ff     <= need_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      acc_ff      <= acc_in;
      rvalid_ff   <= rvalid_in;
      atgap_ff    <= atgap_in;
      rbyte_ff    <= rbyte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // gap never runs past the end of the store
   assert property (@(posedge clock) disable iff (reset)
      ((LW + 1)'(gap_start_ff) + (LW + 1)'(gap_length_ff)) <= (LW + 1)'(CAPACITY))
      else $error("gap extends beyond the store");

   // text length and gap length agree between commands
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         ((LW + 1)'(text_len_ff) + (LW + 1)'(gap_length_ff)) == (LW + 1)'(CAPACITY))
      else $error("text length out of step with gap length");

   // a new response appears only out of the final sequencer step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the final step");

   // a valid read byte only comes with an accepted command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9]) |-> rsp_tdata[0])
      else $error("read valid on a rejected command");

endmodule

>>> sim/text_store_checker.sv
// text_store_checker: watches both streams of the gap buffer text store,
// predicts every response beat and compares it; depends on gbts_pkg only
module text_store_checker
   import gbts_pkg::*;
#(
   parameter int CAPACITY = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending,
   output int               checked_count,
   output int               text_len_seen,
   output int               cursor_seen
);

   // request beat, lsb up: command, position, data_byte, run_remaining, delete_count
   typedef struct packed {
      logic [5:0] fill;
      pos_type    delete_count;
      pos_type    run_remaining;
      byte_type   data_byte;
      pos_type    position;
      cmd_type    command;
   } text_cmd_t;

   // response beat, lsb up: accepted, read_byte, read_valid, at_gap, text_length
   typedef struct packed {
      pos_type  text_length;
      logic     at_gap;
      logic     read_valid;
      byte_type read_byte;
      logic     accepted;
   } text_rsp_t;

   // shadow copy of the store and the gap
   byte_type  text_buf [CAPACITY] = '{default: '0};
   int        gap_lo  = 0;
   int        gap_len = CAPACITY;
   text_rsp_t due_responses [$];
   int        errors  = 0;
   int        checked = 0;

   // slide the gap so that it starts at logical index dest
   function automatic void move_gap(int dest);
      if (dest < gap_lo) begin
         for (int i = gap_lo - 1; i >= dest; i--)
            text_buf[i + gap_len] = text_buf[i];
      end else begin
         for (int i = 0; i < dest - gap_lo; i++)
            text_buf[gap_lo + i] = text_buf[gap_lo + gap_len + i];
      end
      gap_lo = dest;
   endfunction

   // carry out one command on the shadow store and return its response
   function automatic text_rsp_t apply_command(text_cmd_t c);
      text_rsp_t r;
      int        len;
      int        pos;
      int        cnt;
      int        start;
      int        need;
      r   = '0;
      len = CAPACITY - gap_len;
      pos = c.position;
      cnt = c.delete_count;
      case (c.command)
         CMD_READ: begin
            if (pos <= len) begin
               r.accepted = 1'b1;
               r.at_gap   = (pos == gap_lo);
               if (pos < len) begin
                  r.read_valid = 1'b1;
                  r.read_byte  = (pos < gap_lo) ? text_buf[pos] : text_buf[pos + gap_len];
               end
            end
         end
         CMD_INSERT: begin
            // a zero run count counts as a single byte
            need = (c.run_remaining == 0) ? 1 : c.run_remaining;
            if (pos <= len && need <= gap_len) begin
               move_gap(pos);
               text_buf[gap_lo] = c.data_byte;
               gap_lo++;
               gap_len--;
               r.accepted = 1'b1;
            end
         end
         CMD_DEL_FWD, CMD_DEL_BACK: begin
            if (pos <= len) begin
               r.accepted = 1'b1;
               // zero count and backspace at start leave the gap alone
               if (cnt != 0 && !(c.command == CMD_DEL_BACK && pos == 0)) begin
                  start = pos;
                  if (c.command == CMD_DEL_BACK) begin
                     if (cnt > pos) cnt = pos;
                     start = pos - cnt;
                  end
                  if (cnt > len - start) cnt = len - start;
                  move_gap(start);
                  gap_len += cnt;
               end
            end
         end
         CMD_CLEAR: begin
            gap_lo     = 0;
            gap_len    = CAPACITY;
            r.accepted = 1'b1;
         end
         default: ;
      endcase
      r.text_length = pos_type'(CAPACITY - gap_len);
      return r;
   endfunction

   task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // compare response beats in order, then predict newly accepted commands
   always @(posedge clock) begin
      text_rsp_t want;
      text_rsp_t got;
      if (reset) begin
         gap_lo  = 0;
         gap_len = CAPACITY;
         due_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_responses.size() == 0) begin
               $error("response beat with no command waiting: %h", rsp_tdata);
               errors++;
            end else begin
               want = due_responses.pop_front();
               check_field("accepted", want.accepted, got.accepted);
               check_field("read_byte", want.read_byte, got.read_byte);
               check_field("read_valid", want.read_valid, got.read_valid);
               check_field("at_gap", want.at_gap, got.at_gap);
               check_field("text_length", want.text_length, got.text_length);
               checked++;
            end
         end
         if (req_tvalid && req_tready)
            due_responses.push_back(apply_command(text_cmd_t'(req_tdata)));
      end
      fail_count    <= errors;
      checked_count <= checked;
      pending       <= due_responses.size();
      text_len_seen <= CAPACITY - gap_len;
      cursor_seen   <= gap_lo;
   end

endmodule

>>> sim/tb_gap_buffer_text_store.sv
// tb_gap_buffer_text_store: drives editing commands into the gap buffer text
// store and gives the verdict; depends on gbts_pkg, the block and text_store_checker
module tb_gap_buffer_text_store
   import gbts_pkg::*;
();

   localparam int      CAPACITY     = 4096;
   localparam int      RANDOM_ITEMS = 1600;
   localparam int      STALL_LIMIT  = 40000;
   localparam int      HOLD_CYCLES  = 300;
   localparam int      DRAIN_CYCLES = 64;
   localparam int      POS_MAX      = 8191;
   localparam cmd_type CMD_TOP_CODE = '1;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic idle_enable  = 1'b1;
   logic hold_request = 1'b0;

   int fail_count;
   int pending;
   int checked_count;
   int text_len_seen;
   int cursor_seen;
   int quiet_cycles = 0;
   int commands_sent = 0;
   int n_insert = 0, n_read = 0, n_delete = 0, n_clear = 0, n_ignored = 0;

   always #10 clock = ~clock;

   gap_buffer_text_store #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   text_store_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .text_len_seen (text_len_seen),
      .cursor_seen   (cursor_seen)
   );

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= !(idle_enable && $urandom_range(0, 99) < 20);
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no beat moved for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending);
         $display("[gap_buffer_text_store] ERROR");
         $finish;
      end
   end

   // offer one command beat, with an occasional gap before it
   task automatic send_command(cmd_type op, int pos, int data, int run, int cnt);
      if (idle_enable && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tdata  <= {6'd0, 13'(cnt), 13'(run), 8'(data), 13'(pos), op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      case (op)
         CMD_READ:                  n_read++;
         CMD_INSERT:                n_insert++;
         CMD_DEL_FWD, CMD_DEL_BACK: n_delete++;
         CMD_CLEAR:                 n_clear++;
         default:                   n_ignored++;
      endcase
      if (op <= CMD_CLEAR) commands_sent++;
   endtask

   // typed string: bytes at successive positions, count of bytes still to come
   task automatic insert_run(int pos, int run_len, int bytes_sent);
      for (int i = 0; i < bytes_sent; i++)
         send_command(CMD_INSERT, pos + i, $urandom_range(0, 255), run_len - i,
                      $urandom_range(0, POS_MAX));
   endtask

   // edit point: mostly close to the cursor, sometimes anywhere in the text
   function automatic int near_cursor(int len);
      int p;
      if ($urandom_range(0, 99) < 70) p = cursor_seen + $urandom_range(0, 6) - 3;
      else p = $urandom_range(0, len);
      if (p < 0) p = 0;
      if (p > len) p = len;
      return p;
   endfunction

   function automatic int edit_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 6);
      if (r < 95) return $urandom_range(7, 40);
      return $urandom_range(0, POS_MAX);
   endfunction

   // stimulus
   initial begin
      int len;
      int pick;
      int run_len;
      int pos;
      logic held;
      held = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty buffer corners
      send_command(CMD_READ, 0, 0, 0, 0);           // read at end of empty text
      send_command(CMD_READ, 1, 0, 0, 0);           // beyond text
      send_command(CMD_DEL_BACK, 0, 0, 0, 5);       // backspace at start
      send_command(CMD_DEL_FWD, 0, 0, 0, 0);        // zero delete count
      send_command(CMD_INSERT, 0, 8'hFF, CAPACITY, 0);     // run fills whole store
      send_command(CMD_INSERT, 1, 8'h00, CAPACITY + 1, 0); // run does not fit
      send_command(CMD_INSERT, 1, 8'h00, 0, 0);     // zero run count
      send_command(CMD_INSERT, 5, 8'h11, 1, 0);     // insert beyond text
      insert_run(1, 3, 3);
      for (int i = 0; i <= 5; i++) send_command(CMD_READ, i, 0, 0, 0);
      send_command(CMD_DEL_FWD, 1, 0, 0, POS_MAX);  // clamped forward delete
      send_command(CMD_DEL_BACK, 1, 0, 0, 0);
      send_command(CMD_INSERT, 1, 8'h81, 1, 0);
      send_command(CMD_INSERT, 0, 8'h7E, 1, 0);     // gap moves left
      send_command(CMD_DEL_BACK, 3, 0, 0, CAPACITY); // clamped backspace
      send_command(CMD_DEL_FWD, 0, 0, 0, 5);        // clamps to nothing on empty text
      send_command(CMD_READ, POS_MAX, 8'hFF, POS_MAX, POS_MAX);
      send_command(CMD_TOP_CODE, POS_MAX, 8'hFF, POS_MAX, POS_MAX);
      send_command(CMD_CLEAR, 0, 0, 0, 0);

      // random editing session
      while (commands_sent < RANDOM_ITEMS + 25) begin
         idle_enable <= !(commands_sent >= 600 && commands_sent < 900);
         if (!held && commands_sent >= 1000) begin
            hold_request <= 1'b1;
            held = 1'b1;
         end
         len  = text_len_seen;
         pick = $urandom_range(0, 99);
         if (len > 300 && pick < 30) begin
            send_command(CMD_DEL_FWD, near_cursor(len), $urandom_range(0, 255),
                         $urandom_range(0, POS_MAX), $urandom_range(20, 80));
         end else if (pick < 40) begin
            run_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 40);
            insert_run(near_cursor(len), run_len, run_len);
         end else if (pick < 60) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: pos = cursor_seen;
               4:          pos = len;
               5:          pos = ($urandom_range(0, 1) != 0) ? len + 1
                                                              : $urandom_range(0, POS_MAX);
               default:    pos = $urandom_range(0, len);
            endcase
            send_command(CMD_READ, pos, $urandom_range(0, 255),
                         $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
         end else if (pick < 72) begin
            send_command(CMD_DEL_FWD, near_cursor(len), $urandom_range(0, 255),
                         $urandom_range(0, POS_MAX), edit_count());
         end else if (pick < 84) begin
            pos = ($urandom_range(0, 9) == 0) ? 0 : near_cursor(len);
            send_command(CMD_DEL_BACK, pos, $urandom_range(0, 255),
                         $urandom_range(0, POS_MAX), edit_count());
         end else if (pick < 87) begin
            send_command(CMD_CLEAR, $urandom_range(0, POS_MAX), $urandom_range(0, 255),
                         $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
         end else if (pick < 92) begin
            // broken runs: too long for the free space, or cut short
            if ($urandom_range(0, 1) != 0) begin
               insert_run(near_cursor(len),
                          $urandom_range(CAPACITY - len + 1, POS_MAX),
                          $urandom_range(1, 2));
            end else begin
               run_len = $urandom_range(3, 10);
               insert_run(near_cursor(len), run_len, $urandom_range(1, run_len - 1));
            end
         end else begin
            // noise: unknown codes, wild positions, wild run counts
            case ($urandom_range(0, 2))
               0: send_command(cmd_type'($urandom_range(CMD_CLEAR + 1, CMD_TOP_CODE)),
                               $urandom_range(0, POS_MAX), $urandom_range(0, 255),
                               $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
               1: send_command(cmd_type'($urandom_range(CMD_READ, CMD_DEL_BACK)),
                               $urandom_range(0, POS_MAX), $urandom_range(0, 255),
                               $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
               default: send_command(CMD_INSERT, near_cursor(len), $urandom_range(0, 255),
                                     $urandom_range(0, POS_MAX),
                                     $urandom_range(0, POS_MAX));
            endcase
         end
      end
      req_tvalid <= 1'b0;

      // drain: wait for every predicted response, then let the clock run on quietly
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("commands: %0d inserts, %0d reads, %0d deletes, %0d clears, %0d ignored codes",
               n_insert, n_read, n_delete, n_clear, n_ignored);
      $display("responses compared: %0d, mismatches: %0d", checked_count, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("[gap_buffer_text_store] OK");
      else
         $display("[gap_buffer_text_store] ERROR");
      $finish;
   end

endmodule
